// ===== hdl/stream_skip_past_pattern_macros.svh =====
// ---------------------------------------------------------------------------
// stream_skip_past_pattern assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef STREAM_SKIP_PAST_PATTERN_MACROS_SVH
`define STREAM_SKIP_PAST_PATTERN_MACROS_SVH

// same-cycle implication
`define SSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssp: same-cycle check failed");

// next-cycle implication
`define SSP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssp: next-cycle check failed");

`endif

// ===== hdl/ssp_pkg.sv =====
// ---------------------------------------------------------------------------
// ssp_pkg
// Constants and types shared by the skip-past-pattern stream filter.
// ---------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

	localparam int MAX_PATTERN   = 32;
	localparam int BYTE_W        = 8;
	localparam int WORD_W        = 64;
	localparam int PATTERN_WORDS = 4;
	localparam int CNT_W         = $clog2(MAX_PATTERN + 1);
	localparam int CFG_IDX_W     = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATTERN);

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_WORD_0 = 3'd1,
		REG_PATTERN_WORD_1 = 3'd2,
		REG_PATTERN_WORD_2 = 3'd3,
		REG_PATTERN_WORD_3 = 3'd4
	} cfg_reg_t;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

// ===== hdl/ssp_stream_if.sv =====
// ---------------------------------------------------------------------------
// ssp stream interfaces
// Valid/ready byte channels for the input and the result side.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssp_in_if;
	logic           valid;
	logic           ready;
	ssp_pkg::byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface ssp_out_if;
	logic           valid;
	logic           ready;
	ssp_pkg::byte_t out_byte;

	modport source (output valid, output out_byte, input ready);
	modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/stream_skip_past_pattern.sv =====
// ---------------------------------------------------------------------------
// stream_skip_past_pattern
// Drops stream bytes up to and including the end of the first occurrence of
// a configured pattern, then passes every later byte through unchanged.
// ---------------------------------------------------------------------------
//
//  channel   | role   | payload        | notes
//  ----------+--------+----------------+-------------------------------------
//  in_s      | sink   | in_byte  [7:0] | one raw byte per transaction
//  out_s     | source | out_byte [7:0] | bytes after the match only
//  cfg_*     | write  | cfg_wdata[63:0]| length and four pattern words
//
//  Throughput is one byte per clock while results are not stalled; an input
//  byte goes through the input register, then the result register.
//  The match is a 32-byte parallel compare of the shifted window against a
//  pre-aligned copy of the pattern, all within the input-to-result stage.
//  Reset clears control state and the window; no clearing pass is needed.
//  A stalled result holds its register; input is still taken while the
//  pattern is not yet found, since those bytes produce no result.
//
`default_nettype none

`include "stream_skip_past_pattern_macros.svh"

module stream_skip_past_pattern (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ssp_pkg::WORD_W-1:0]     cfg_wdata,
	ssp_in_if.sink                              in_s,
	ssp_out_if.source                           out_s
);

	localparam int MP = ssp_pkg::MAX_PATTERN;
	localparam int CW = ssp_pkg::CNT_W;

	// configuration registers
	logic [CW-1:0]                                     len_cfg_q;
	logic [ssp_pkg::PATTERN_WORDS-1:0][ssp_pkg::WORD_W-1:0] pat_word_q;

	// derived pattern view, realigned every cycle
	logic [CW-1:0]                       len_eff_d, len_eff_q;
	logic [MP-1:0][ssp_pkg::BYTE_W-1:0]  pat_bytes;
	logic [MP-1:0][ssp_pkg::BYTE_W-1:0]  align_d, align_q;
	logic [MP-1:0]                       mask_d, mask_q;

	// search state
	logic [MP-1:0][ssp_pkg::BYTE_W-1:0]  window_q, window_next;
	logic [CW-1:0]                       bytes_seen_q, seen_next;
	logic                                found_q;
	logic [MP-1:0]                       byte_ok;
	logic                                match;

	// input stage and result register
	logic            s1_valid_q;
	ssp_pkg::byte_t  byte_s1;
	logic            s1_advance;
	logic            s1_fire;
	logic            out_valid_q;
	ssp_pkg::byte_t  out_byte_q;

	// configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q  <= CW'(1);
			pat_word_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssp_pkg::REG_PATTERN_LENGTH: len_cfg_q     <= cfg_wdata[CW-1:0];
				ssp_pkg::REG_PATTERN_WORD_0: pat_word_q[0] <= cfg_wdata;
				ssp_pkg::REG_PATTERN_WORD_1: pat_word_q[1] <= cfg_wdata;
				ssp_pkg::REG_PATTERN_WORD_2: pat_word_q[2] <= cfg_wdata;
				ssp_pkg::REG_PATTERN_WORD_3: pat_word_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp length to 1..MAX_PATTERN
	always_comb begin
		if (len_cfg_q == '0) begin
			len_eff_d = CW'(1);
		end else if (len_cfg_q > ssp_pkg::CNT_MAX) begin
			len_eff_d = ssp_pkg::CNT_MAX;
		end else begin
			len_eff_d = len_cfg_q;
		end
	end

	assign pat_bytes = pat_word_q;

	// reverse the pattern so window slot i faces pattern byte len-1-i
	always_comb begin
		logic [CW-1:0] pidx;
		for (int i = 0; i < MP; i++) begin
			pidx       = len_eff_d - CW'(1) - CW'(i);
			mask_d[i]  = CW'(i) < len_eff_d;
			align_d[i] = pat_bytes[pidx[CW-2:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_eff_q <= CW'(1);
			align_q   <= '0;
			mask_q    <= MP'(1);
		end else begin
			len_eff_q <= len_eff_d;
			align_q   <= align_d;
			mask_q    <= mask_d;
		end
	end

	// handshake: results only block the pipe once the pattern is found
	assign s1_advance = !found_q || !out_valid_q || out_s.ready;
	assign s1_fire    = s1_valid_q && s1_advance;
	assign in_s.ready = !s1_valid_q || s1_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_s.ready) begin
			s1_valid_q <= in_s.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_s.ready && in_s.valid) begin
			byte_s1 <= in_s.in_byte;
		end
	end

	// shifted window, saturating count and tail compare
	always_comb begin
		window_next = {window_q[MP-2:0], byte_s1};
		seen_next   = (bytes_seen_q == ssp_pkg::CNT_MAX) ? bytes_seen_q
		                                                 : bytes_seen_q + CW'(1);
		for (int i = 0; i < MP; i++) begin
			byte_ok[i] = !mask_q[i] || (window_next[i] == align_q[i]);
		end
		match = (&byte_ok) && (seen_next >= len_eff_q);
	end

	// search state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			bytes_seen_q <= '0;
			found_q      <= 1'b0;
		end else if (s1_fire && !found_q) begin
			window_q     <= window_next;
			bytes_seen_q <= seen_next;
			found_q      <= match;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && found_q) begin
			out_valid_q <= 1'b1;
		end else if (out_s.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && found_q) begin
			out_byte_q <= byte_s1;
		end
	end

	assign out_s.valid    = out_valid_q;
	assign out_s.out_byte = out_byte_q;

	// checks
	`SSP_ASSERT_NXT(a_found_sticky, found_q, found_q)
	`SSP_ASSERT_IMP(a_out_after_found, out_valid_q, found_q)
	`SSP_ASSERT_NXT(a_window_frozen, found_q, $stable(window_q) && $stable(bytes_seen_q))
	`SSP_ASSERT_NXT(a_count_steps,
		s1_fire && !found_q && (bytes_seen_q != ssp_pkg::CNT_MAX),
		bytes_seen_q == $past(bytes_seen_q) + CW'(1))
	`SSP_ASSERT_IMP(a_stall_holds, out_valid_q && !out_s.ready && s1_valid_q && found_q,
		!in_s.ready)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: stream_skip_past_pattern
// Streams bytes through the filter and checks that nothing passes before the
// first full pattern occurrence, then every later byte passes unchanged.
// Expected bytes come from a window predictor updated on each input transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	// indexes that decode to no register
	localparam logic [ssp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
	localparam logic [ssp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;
	// cycles to let the two-stage pipeline settle before a register write
	localparam int DRAIN_CYCLES = 4;
	// quiet cycles at the end to catch stray results
	localparam int TAIL_CYCLES  = 8;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ssp_pkg::WORD_W-1:0]    cfg_wdata;

	ssp_in_if  in_if ();
	ssp_out_if out_if ();

	stream_skip_past_pattern dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_s      (in_if),
		.out_s     (out_if)
	);

	// predictor state: register copies, byte window (newest first), count, flag
	logic [5:0]                 len_reg = 6'd1;
	logic [ssp_pkg::WORD_W-1:0] pat_word [ssp_pkg::PATTERN_WORDS] = '{default: '0};
	ssp_pkg::byte_t             hist [ssp_pkg::MAX_PATTERN] = '{default: '0};
	int unsigned                hist_cnt = 0;
	bit                         pattern_found = 1'b0;

	ssp_pkg::byte_t byte_q [$];
	ssp_pkg::byte_t passed_q [$];
	int unsigned    err_cnt = 0;
	bit             idle_off = 1'b0;
	int unsigned    gap_left = 0;
	int unsigned    stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pattern length in use after clamping
	function automatic int unsigned match_len();
		int unsigned n;
		n = len_reg;
		if (n == 0)
			n = 1;
		if (n > ssp_pkg::MAX_PATTERN)
			n = ssp_pkg::MAX_PATTERN;
		return n;
	endfunction

	function automatic ssp_pkg::byte_t pattern_at(int unsigned idx);
		return pat_word[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	// shift a byte into the window until the pattern is found; returns 1 when the byte passes
	function automatic bit skip_filter(ssp_pkg::byte_t b);
		int unsigned n;
		int unsigned i;
		bit hit;
		if (pattern_found)
			return 1'b1;
		for (i = ssp_pkg::MAX_PATTERN - 1; i > 0; i--)
			hist[i] = hist[i - 1];
		hist[0] = b;
		if (hist_cnt < ssp_pkg::MAX_PATTERN)
			hist_cnt++;
		n = match_len();
		hit = (hist_cnt >= n);
		for (i = 0; i < n; i++)
			if (hist[n - 1 - i] != pattern_at(i))
				hit = 1'b0;
		if (hit)
			pattern_found = 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [ssp_pkg::WORD_W-1:0] word_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// input driver: predicts on each transaction, then presents the next byte
	always @(posedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.in_byte <= '0;
			gap_left = 0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				if (skip_filter(in_if.in_byte))
					passed_q.push_back(in_if.in_byte);
			end
			if (!in_if.valid || in_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_if.valid <= 1'b0;
				end else if (!idle_off && byte_q.size() != 0 && $urandom_range(0, 6) == 0) begin
					gap_left = $urandom_range(1, 14) - 1;
					in_if.valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					in_if.valid <= 1'b1;
					in_if.in_byte <= byte_q.pop_front();
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stalls
	always @(posedge clk) begin
		ssp_pkg::byte_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (passed_q.size() == 0) begin
					$display("%0t: unexpected out_byte: expected none, actual %02h",
						$time, out_if.out_byte);
					err_cnt++;
				end else begin
					want = passed_q.pop_front();
					if (want !== out_if.out_byte) begin
						$display("%0t: out_byte mismatch: expected %02h, actual %02h",
							$time, want, out_if.out_byte);
						err_cnt++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_if.ready <= 1'b0;
			end else if (!idle_off && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// wait for queued bytes and results, then for the pipeline to settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (byte_q.size() != 0 || in_if.valid || passed_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ssp_pkg::CFG_IDX_W-1:0] idx,
		input logic [ssp_pkg::WORD_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			ssp_pkg::REG_PATTERN_LENGTH: len_reg = data[5:0];
			ssp_pkg::REG_PATTERN_WORD_0: pat_word[0] = data;
			ssp_pkg::REG_PATTERN_WORD_1: pat_word[1] = data;
			ssp_pkg::REG_PATTERN_WORD_2: pat_word[2] = data;
			ssp_pkg::REG_PATTERN_WORD_3: pat_word[3] = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// length with random upper bits, then four pattern words
	task automatic program_pattern(input logic [5:0] len_val);
		logic [ssp_pkg::WORD_W-1:0] d;
		d = {$urandom, $urandom};
		d[5:0] = len_val;
		cfg_write(ssp_pkg::REG_PATTERN_LENGTH, d);
		cfg_write(ssp_pkg::REG_PATTERN_WORD_0, word_value());
		cfg_write(ssp_pkg::REG_PATTERN_WORD_1, word_value());
		cfg_write(ssp_pkg::REG_PATTERN_WORD_2, word_value());
		cfg_write(ssp_pkg::REG_PATTERN_WORD_3, word_value());
	endtask

	task automatic push_other(input ssp_pkg::byte_t avoid);
		byte_q.push_back(avoid ^ ssp_pkg::byte_t'($urandom_range(1, 255)));
	endtask

	// noise, near misses and corrupted copies; no piece on its own ends on a full match
	task automatic push_search_traffic(input int unsigned target);
		int unsigned n;
		int unsigned j;
		int unsigned k;
		int unsigned pushed;
		ssp_pkg::byte_t b;
		ssp_pkg::byte_t last_b;
		n = match_len();
		last_b = pattern_at(n - 1);
		pushed = 0;
		while (pushed < target) begin
			case ($urandom_range(0, 2))
				0: begin
					k = $urandom_range(1, 6);
					repeat (k) push_other(last_b);
					pushed += k;
				end
				1: begin
					for (j = 0; j + 1 < n; j++)
						byte_q.push_back(pattern_at(j));
					push_other(last_b);
					pushed += n;
				end
				default: begin
					if (n > 1) begin
						k = $urandom_range(0, n - 2);
						for (j = 0; j < n; j++) begin
							b = pattern_at(j);
							if (j == k)
								b ^= ssp_pkg::byte_t'($urandom_range(1, 255));
							byte_q.push_back(b);
						end
						pushed += n;
					end else begin
						push_other(last_b);
						pushed++;
					end
				end
			endcase
		end
	endtask

	initial begin
		int unsigned p;
		int unsigned j;
		int unsigned k;
		int unsigned n;
		logic [ssp_pkg::WORD_W-1:0] d;

		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= ssp_pkg::REG_PATTERN_LENGTH;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero pattern over the zero window must still wait for enough bytes
		cfg_write(ssp_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		wait_drained();

		// length zero acts as one; unmapped indexes are dropped
		cfg_write(ssp_pkg::REG_PATTERN_LENGTH, 64'h0);
		cfg_write(ssp_pkg::REG_PATTERN_WORD_0, 64'hA5A5_A5A5_A5A5_A55A);
		cfg_write(REG_UNMAPPED_FIRST, '1);
		cfg_write(REG_UNMAPPED_LAST, '1);
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hA5);
		byte_q.push_back(8'h01);
		byte_q.push_back(8'h80);
		wait_drained();

		// compare reaches back to bytes taken under the old pattern
		cfg_write(ssp_pkg::REG_PATTERN_LENGTH, 64'h3);
		cfg_write(ssp_pkg::REG_PATTERN_WORD_0, 64'h0000_0000_007E_8001);
		byte_q.push_back(8'h7F);
		wait_drained();

		// search phases across lengths, extremes first
		for (p = 0; p < 8; p++) begin
			idle_off = ($urandom_range(0, 3) == 0);
			case (p)
				0: k = 63;
				1: k = 32;
				2: k = 0;
				3: k = 1;
				default: begin
					case ($urandom_range(0, 3))
						0: k = $urandom_range(33, 62);
						1: k = $urandom_range(2, 31);
						default: k = $urandom_range(2, 8);
					endcase
				end
			endcase
			program_pattern(k[5:0]);
			push_search_traffic(25);
			wait_drained();
		end

		// the match, split around a length rewrite that keeps its value
		idle_off = 1'b0;
		k = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 6);
		program_pattern(k[5:0]);
		n = match_len();
		repeat ($urandom_range(2, 8)) push_other(pattern_at(n - 1));
		p = $urandom_range(0, n - 1);
		for (j = 0; j < p; j++)
			byte_q.push_back(pattern_at(j));
		wait_drained();
		d = {$urandom, $urandom};
		d[5:0] = k[5:0];
		cfg_write(ssp_pkg::REG_PATTERN_LENGTH, d);
		for (j = p; j < n; j++)
			byte_q.push_back(pattern_at(j));

		// every later byte passes; register writes no longer matter
		for (p = 0; p < 5; p++) begin
			idle_off = (p == 4) ? 1'b1 : ($urandom_range(0, 3) == 0);
			repeat (50) byte_q.push_back(ssp_pkg::byte_t'($urandom));
			wait_drained();
			if (p < 4) begin
				program_pattern(6'($urandom_range(0, 63)));
				cfg_write(REG_UNMAPPED_FIRST, {$urandom, $urandom});
			end
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("** stream_skip_past_pattern: PASSED **");
		else
			$display("** stream_skip_past_pattern: FAILED **");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("%0t: timeout", $time);
		$display("** stream_skip_past_pattern: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ssp_pkg.sv
hdl/ssp_stream_if.sv
hdl/stream_skip_past_pattern.sv
tb/tb.sv
